>>> design/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the link frame decoder
// Register indexes, status codes, CRC-15 byte update, and the record types
// that pass between the frame parser and the result emitter.
// ----------------------------------------------------------------------------
package lfd_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int LEN_W      = 5;

	localparam logic [CFG_ADDR_W-1:0] REG_SYNC_BYTE       = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KNOWN_TYPE_MASK = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VERSION_MAJOR   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_LENGTH      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH      = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
	localparam logic [2:0] ST_SHORT     = 3'd2;
	localparam logic [2:0] ST_LEN_RANGE = 3'd3;
	localparam logic [2:0] ST_LEN_MISM  = 3'd4;
	localparam logic [2:0] ST_CRC       = 3'd5;
	localparam logic [2:0] ST_UNK_TYPE  = 3'd6;

	localparam logic [14:0] CRC_POLY = 15'h0F9D;
	localparam logic [14:0] CRC_INIT = 15'h7FFF;

	// sync, version, type, length, role come before the payload
	localparam logic [7:0] PAYLOAD_START  = 8'd5;
	// header plus two CRC bytes
	localparam logic [7:0] FRAME_OVERHEAD = 8'd7;
	// byte count at which the CRC starts being fed from the delay line, version byte first
	localparam logic [7:0] CRC_FEED_START = 8'd3;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [31:0] known_type_mask;
		logic [3:0]  version_major;
		logic [4:0]  min_length;
		logic [4:0]  max_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       version;
		logic [7:0]       msg_type;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       sender_role;
		logic             version_mismatch;
		logic [15:0]      crc_received;
		logic [14:0]      crc_computed;
		logic [LEN_W-1:0] count;         // results to emit, at least one
		logic             zero_payload;  // error or empty frame
	} frame_rec_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  version;
		logic [7:0]  msg_type;
		logic [4:0]  payload_length;
		logic [7:0]  sender_role;
		logic        version_mismatch;
		logic [15:0] crc_received;
		logic [14:0] crc_computed;
		logic [7:0]  payload_byte;
		logic [3:0]  payload_index;
	} result_t;

	// CRC-15, MSB first, one byte
	function automatic logic [14:0] crc_feed(input logic [14:0] crc_in, input logic [7:0] b);
		logic [14:0] c;
		c = crc_in ^ {b, 7'd0};
		for (int i = 0; i < 8; i++) begin
			if (c[14]) begin
				c = {c[13:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[13:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> design/link_frame_decoder.sv
// ----------------------------------------------------------------------------
// link_frame_decoder: framed packet receiver with CRC-15 check
// Parses sync/version/type/length/role/payload/CRC frames byte by byte and
// emits per-payload-byte results for good frames or one status result.
// ----------------------------------------------------------------------------
// One frame byte is taken per cycle while the input is not held. Each byte
// passes an input register, then parsing (header capture, byte-wide CRC-15
// update, frame checks at the end byte) that loads the result sequencer,
// which registers the record that gives the first result of the frame.
// Results leave one per cycle while the output is ready: a good frame gives
// one per payload byte (one for an empty payload), any error one status
// result, last result of a frame marked by tlast. A good frame of L payload
// bytes has L+7 bytes, so good frames back to back do not stall the input
// while the output is ready unless a payload is over seven bytes longer than
// the next frame's. The input waits when a frame end reaches the parser while
// the previous frame's results are still pending: a short or broken frame
// right after a long good one, or results held back by the output side. No
// clearing pass after reset. The user writes the configuration registers via
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module link_frame_decoder #(
	parameter int PAYLOAD_DEPTH     = 16,
	parameter int LONG_LENGTH_LIMIT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [lfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [lfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// byte input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	input  logic                           s_axis_tlast,  // end_of_frame
	// result output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] version, [15:8] msg_type, [20:16] payload_length,
	// [28:21] sender_role, [29] version_mismatch, [45:30] crc_received,
	// [60:46] crc_computed, [68:61] payload_byte, [72:69] payload_index,
	// [79:73] zero
	output logic [79:0]                    m_axis_tdata,
	output logic [2:0]                     m_axis_tuser,  // [2:0] status
	output logic                           m_axis_tlast   // last_result
);

	lfd_pkg::cfg_t       cfg_q;
	lfd_pkg::frame_rec_t rec;
	lfd_pkg::result_t    res;

	logic       s1_valid_q;
	logic [7:0] s1_byte_q;
	logic       s1_eof_q;
	logic       step;
	logic       rec_valid;
	logic       can_load;
	logic [7:0] store [PAYLOAD_DEPTH];

	// configuration registers; writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte       <= 8'd0;
			cfg_q.known_type_mask <= 32'd0;
			cfg_q.version_major   <= 4'd1;
			cfg_q.min_length      <= 5'd5;
			cfg_q.max_length      <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				lfd_pkg::REG_SYNC_BYTE:       cfg_q.sync_byte       <= cfg_wdata[7:0];
				lfd_pkg::REG_KNOWN_TYPE_MASK: cfg_q.known_type_mask <= cfg_wdata[31:0];
				lfd_pkg::REG_VERSION_MAJOR:   cfg_q.version_major   <= cfg_wdata[3:0];
				lfd_pkg::REG_MIN_LENGTH:      cfg_q.min_length      <= cfg_wdata[4:0];
				lfd_pkg::REG_MAX_LENGTH:      cfg_q.max_length      <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// the held byte moves on unless it ends a frame and the sequencer is full
	assign step          = s1_valid_q && (!s1_eof_q || can_load);
	assign s_axis_tready = !s1_valid_q || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			s1_byte_q <= s_axis_tdata;
			s1_eof_q  <= s_axis_tlast;
		end
	end

	lfd_parser #(
		.PAYLOAD_DEPTH     (PAYLOAD_DEPTH),
		.LONG_LENGTH_LIMIT (LONG_LENGTH_LIMIT)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.step         (step),
		.rx_byte      (s1_byte_q),
		.end_of_frame (s1_eof_q),
		.rec_valid    (rec_valid),
		.rec          (rec),
		.store        (store)
	);

	lfd_emitter #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.store     (store),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res),
		.last      (m_axis_tlast)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {7'd0, res.payload_index, res.payload_byte, res.crc_computed,
		res.crc_received, res.version_mismatch, res.sender_role, res.payload_length,
		res.msg_type, res.version};

	a_eof_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_eof_q && !can_load |-> !s_axis_tready && !rec_valid)
		else $error("frame end passed a full sequencer");

	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !step |=> s1_valid_q && $stable(s1_byte_q) && $stable(s1_eof_q))
		else $error("held input byte changed while stalled");

	a_rec_step: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> step && can_load)
		else $error("frame record raised without room");

endmodule

>>> design/lfd_parser.sv
// ----------------------------------------------------------------------------
// lfd_parser: byte-serial frame parser
// Tracks header bytes, payload store and CRC per byte; at frame end runs the
// frame checks and hands a result record plus the payload to the emitter.
// ----------------------------------------------------------------------------
module lfd_parser #(
	parameter int PAYLOAD_DEPTH     = 16,
	parameter int LONG_LENGTH_LIMIT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfd_pkg::cfg_t       cfg,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic                end_of_frame,
	output logic                rec_valid,
	output lfd_pkg::frame_rec_t rec,
	output logic [7:0]          store [PAYLOAD_DEPTH]
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [7:0]  count_q;
	logic [14:0] crc_q;
	logic [7:0]  d0_q, d1_q;
	logic [7:0]  first_q, ver_q, typ_q, len_q, role_q;
	logic [7:0]  store_q [PAYLOAD_DEPTH];

	logic [7:0]  first_n, ver_n, typ_n, len_n, role_n, count_n;
	logic [14:0] crc_n, crc_local;
	logic [15:0] crc_field;
	logic [7:0]  pofs;
	logic        pwrite;
	logic [6:0]  hi_len;
	logic [2:0]  status;

	always_comb begin
		first_n = (count_q == 8'd0) ? rx_byte : first_q;
		ver_n   = (count_q == 8'd1) ? rx_byte : ver_q;
		typ_n   = (count_q == 8'd2) ? rx_byte : typ_q;
		len_n   = (count_q == 8'd3) ? rx_byte : len_q;
		role_n  = (count_q == 8'd4) ? rx_byte : role_q;
		count_n = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
		crc_n   = (count_q >= lfd_pkg::CRC_FEED_START) ? lfd_pkg::crc_feed(crc_q, d0_q) : crc_q;
		crc_local = ~crc_n;
		crc_field = {d1_q, rx_byte};
		pofs   = count_q - lfd_pkg::PAYLOAD_START;
		pwrite = (count_q >= lfd_pkg::PAYLOAD_START) && (pofs < 8'(PAYLOAD_DEPTH));
		hi_len = ({2'd0, cfg.max_length} > 7'(PAYLOAD_DEPTH)) ?
			7'(PAYLOAD_DEPTH) : {2'd0, cfg.max_length};
	end

	// checks in priority order
	always_comb begin
		if (count_n < lfd_pkg::FRAME_OVERHEAD) begin
			status = lfd_pkg::ST_SHORT;
		end else if (first_n != cfg.sync_byte) begin
			status = lfd_pkg::ST_BAD_SYNC;
		end else if ({1'b0, len_n} > 9'(LONG_LENGTH_LIMIT)) begin
			status = lfd_pkg::ST_LEN_RANGE;
		end else if ({1'b0, count_n} != {1'b0, lfd_pkg::FRAME_OVERHEAD} + {1'b0, len_n}) begin
			status = lfd_pkg::ST_LEN_MISM;
		end else if (crc_field != {1'b0, crc_local}) begin
			status = lfd_pkg::ST_CRC;
		end else if (len_n < {3'd0, cfg.min_length} || len_n > {1'b0, hi_len}) begin
			status = lfd_pkg::ST_LEN_RANGE;
		end else if (typ_n >= 8'd32 || !cfg.known_type_mask[typ_n[4:0]]) begin
			status = lfd_pkg::ST_UNK_TYPE;
		end else begin
			status = lfd_pkg::ST_OK;
		end
	end

	always_comb begin
		rec_valid = step && end_of_frame;
		rec = '0;
		rec.count = lfd_pkg::LEN_W'(1);
		rec.zero_payload = 1'b1;
		rec.status = status;
		if (status == lfd_pkg::ST_OK) begin
			rec.version          = ver_n;
			rec.msg_type         = typ_n;
			rec.payload_length   = len_n[lfd_pkg::LEN_W-1:0];
			rec.sender_role      = role_n;
			rec.version_mismatch = (ver_n[7:4] != cfg.version_major);
			rec.crc_received     = crc_field;
			rec.crc_computed     = crc_local;
			rec.zero_payload     = (len_n == 8'd0);
			if (len_n != 8'd0) begin
				rec.count = len_n[lfd_pkg::LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= lfd_pkg::CRC_INIT;
			d0_q    <= '0;
			d1_q    <= '0;
			first_q <= '0;
			ver_q   <= '0;
			typ_q   <= '0;
			len_q   <= '0;
			role_q  <= '0;
		end else if (step) begin
			if (end_of_frame) begin
				count_q <= '0;
				crc_q   <= lfd_pkg::CRC_INIT;
				d0_q    <= '0;
				d1_q    <= '0;
				first_q <= '0;
				ver_q   <= '0;
				typ_q   <= '0;
				len_q   <= '0;
				role_q  <= '0;
			end else begin
				count_q <= count_n;
				crc_q   <= crc_n;
				d0_q    <= d1_q;
				d1_q    <= rx_byte;
				first_q <= first_n;
				ver_q   <= ver_n;
				typ_q   <= typ_n;
				len_q   <= len_n;
				role_q  <= role_n;
			end
		end
	end

	// payload store, contents undefined until written
	always_ff @(posedge clk) begin
		if (step && pwrite) begin
			store_q[AW'(pofs)] <= rx_byte;
		end
	end

	assign store = store_q;

endmodule

>>> design/lfd_emitter.sv
// ----------------------------------------------------------------------------
// lfd_emitter: result sequencer
// Holds one frame record and its payload copy and walks out one result per
// transfer; a new record may load on the cycle the last result leaves.
// ----------------------------------------------------------------------------
module lfd_emitter #(
	parameter int PAYLOAD_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	input  lfd_pkg::frame_rec_t rec,
	input  logic [7:0]          store [PAYLOAD_DEPTH],
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output lfd_pkg::result_t    res,
	output logic                last
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic                      busy_q;
	logic [lfd_pkg::LEN_W-1:0] k_q;
	lfd_pkg::frame_rec_t       rec_q;
	logic [7:0]                buf_q [PAYLOAD_DEPTH];
	logic                      xfer;

	assign last      = (k_q == rec_q.count - lfd_pkg::LEN_W'(1));
	assign xfer      = busy_q && out_ready;
	assign can_load  = !busy_q || (xfer && last);
	assign out_valid = busy_q;

	always_comb begin
		res.status           = rec_q.status;
		res.version          = rec_q.version;
		res.msg_type         = rec_q.msg_type;
		res.payload_length   = rec_q.payload_length;
		res.sender_role      = rec_q.sender_role;
		res.version_mismatch = rec_q.version_mismatch;
		res.crc_received     = rec_q.crc_received;
		res.crc_computed     = rec_q.crc_computed;
		res.payload_byte     = rec_q.zero_payload ? 8'd0 : buf_q[AW'(k_q)];
		res.payload_index    = k_q[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (rec_valid && can_load) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (xfer) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + lfd_pkg::LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && can_load) begin
			rec_q <= rec;
			buf_q <= store;
		end
	end

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && rec_q.status != lfd_pkg::ST_OK |-> last && k_q == '0)
		else $error("error frame has more than one result");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !last |=> busy_q && k_q == $past(k_q) + lfd_pkg::LEN_W'(1))
		else $error("payload index did not advance after transfer");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && rec_q.zero_payload |-> res.payload_byte == 8'd0)
		else $error("payload byte nonzero on error or empty frame");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for link_frame_decoder
// Byte frames go in through the input stream and are mirrored by a cycle-free
// frame predictor. Each result transfer is checked field by field against the
// oldest predicted result. Register settings change between phases while the
// block is drained, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH          = 16;   // payload buffer entries
	localparam int LONG_LIMIT     = 64;   // length field above this is a range error
	localparam int HDR_BYTES      = 7;    // header plus CRC field
	localparam int PHASES         = 6;
	localparam int RAND_BYTES     = 4;    // at least this many random bytes per phase, whole frames
	localparam int HOLD_CYCLES    = 120;  // long output stall

	// one input transfer: frame byte and end-of-frame marker
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_xfer_t;

	// one output transfer: decoded fields plus last-of-frame marker
	typedef struct packed {
		lfd_pkg::result_t fields;
		logic             last;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           cfg_we = 1'b0;
	logic [lfd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [lfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
	logic        s_axis_tlast = 1'b0;   // end_of_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;         // version .. payload_index, see dut port list
	logic [2:0]  m_axis_tuser;         // [2:0] status
	logic        m_axis_tlast;         // last_result

	link_frame_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// stimulus and expectation stores
	byte_xfer_t    pending_bytes[$];
	frame_result_t expected_results[$];

	// run-time knobs, set by the sequencer
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit pressure_go = 1'b0;

	// bookkeeping
	int bytes_queued = 0;
	int bytes_sent = 0;
	int frames_seen = 0;
	int results_checked = 0;
	int mismatches = 0;
	int settings_done = 0;
	int status_seen[0:7];

	// predictor copy of the registers
	logic [7:0]  cfg_sync;
	logic [31:0] cfg_mask;
	logic [3:0]  cfg_vmaj;
	logic [4:0]  cfg_min;
	logic [4:0]  cfg_max;

	// predictor copy of the frame state
	int          rx_count;
	logic [14:0] crc_acc;
	logic [7:0]  dly [0:1];
	logic [7:0]  hdr_sync, hdr_ver, hdr_type, hdr_len, hdr_role;
	logic [7:0]  payload_mem [0:DEPTH-1];

	// CRC-15, bit-serial form: feedback is the top bit xor the incoming bit
	function automatic logic [14:0] crc15_next(input logic [14:0] c, input logic [7:0] b);
		logic [14:0] r;
		logic        fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[14] ^ b[i];
			r = {r[13:0], 1'b0} ^ (fb ? lfd_pkg::CRC_POLY : 15'd0);
		end
		return r;
	endfunction

	task automatic clear_frame();
		rx_count = 0;
		crc_acc = lfd_pkg::CRC_INIT;
		dly[0] = 8'd0;
		dly[1] = 8'd0;
		hdr_sync = 8'd0;
		hdr_ver = 8'd0;
		hdr_type = 8'd0;
		hdr_len = 8'd0;
		hdr_role = 8'd0;
	endtask

	// Mirror one accepted byte; at frame end push the expected result records.
	task automatic decode_byte(input logic [7:0] b, input logic eof);
		int            p;
		int            hi;
		int            cnt;
		logic [15:0]   crc_rx;
		logic [14:0]   crc_loc;
		logic [2:0]    st;
		frame_result_t r;
		p = rx_count;
		case (p)
			0: hdr_sync = b;
			1: hdr_ver = b;
			2: hdr_type = b;
			3: hdr_len = b;
			4: hdr_role = b;
			default: begin
				if (p - 5 < DEPTH) payload_mem[p - 5] = b;
			end
		endcase
		// CRC sees bytes two behind, so the trailing CRC field never enters it
		if (p >= 3) crc_acc = crc15_next(crc_acc, dly[0]);
		dly[0] = dly[1];
		dly[1] = b;
		if (rx_count < 255) rx_count++;
		if (!eof) return;

		frames_seen++;
		crc_rx = {dly[0], dly[1]};
		crc_loc = ~crc_acc;
		hi = (cfg_max > DEPTH) ? DEPTH : cfg_max;
		// checks in priority order
		if (rx_count < HDR_BYTES)
			st = lfd_pkg::ST_SHORT;
		else if (hdr_sync != cfg_sync)
			st = lfd_pkg::ST_BAD_SYNC;
		else if (hdr_len > LONG_LIMIT)
			st = lfd_pkg::ST_LEN_RANGE;
		else if (rx_count != HDR_BYTES + hdr_len)
			st = lfd_pkg::ST_LEN_MISM;
		else if (crc_rx != {1'b0, crc_loc})
			st = lfd_pkg::ST_CRC;
		else if (hdr_len < cfg_min || hdr_len > hi)
			st = lfd_pkg::ST_LEN_RANGE;
		else if (hdr_type >= 32 || !cfg_mask[hdr_type[4:0]])
			st = lfd_pkg::ST_UNK_TYPE;
		else
			st = lfd_pkg::ST_OK;
		status_seen[st]++;

		if (st != lfd_pkg::ST_OK) begin
			// error: one status record, everything else zero
			r = '0;
			r.fields.status = st;
			r.last = 1'b1;
			expected_results.push_back(r);
		end else begin
			// empty payload still gives one record
			cnt = (hdr_len == 0) ? 1 : hdr_len;
			for (int k = 0; k < cnt; k++) begin
				r = '0;
				r.fields.status = lfd_pkg::ST_OK;
				r.fields.version = hdr_ver;
				r.fields.msg_type = hdr_type;
				r.fields.payload_length = hdr_len[4:0];
				r.fields.sender_role = hdr_role;
				r.fields.version_mismatch = (hdr_ver[7:4] != cfg_vmaj);
				r.fields.crc_received = crc_rx;
				r.fields.crc_computed = crc_loc;
				r.fields.payload_byte = (hdr_len == 0) ? 8'd0 : payload_mem[k];
				r.fields.payload_index = k[3:0];
				r.last = (k == cnt - 1);
				expected_results.push_back(r);
			end
		end
		clear_frame();
	endtask

	// Build a frame with a correct CRC, then optionally spoil it:
	// crc_xor flips CRC field bits, keep > 0 cuts the frame to keep bytes.
	task automatic queue_frame(input logic [7:0] sync_v, input logic [7:0] ver,
			input logic [7:0] typ, input logic [7:0] len_f, input logic [7:0] role,
			input int pay_n, input logic [15:0] crc_xor, input int keep);
		logic [7:0]  fb [$];
		logic [14:0] c;
		logic [15:0] fld;
		byte_xfer_t  x;
		int          total;
		fb = {sync_v, ver, typ, len_f, role};
		for (int i = 0; i < pay_n; i++) fb.push_back(8'($urandom_range(255)));
		c = lfd_pkg::CRC_INIT;
		for (int i = 1; i < fb.size(); i++) c = crc15_next(c, fb[i]);
		fld = {1'b0, ~c} ^ crc_xor;
		fb.push_back(fld[15:8]);
		fb.push_back(fld[7:0]);
		total = (keep > 0 && keep < fb.size()) ? keep : fb.size();
		for (int i = 0; i < total; i++) begin
			x.data = fb[i];
			x.last = (i == total - 1);
			pending_bytes.push_back(x);
		end
		bytes_queued += total;
	endtask

	// random bytes with an end marker on the final one
	task automatic queue_noise(input int n);
		byte_xfer_t x;
		for (int i = 0; i < n; i++) begin
			x.data = 8'($urandom_range(255));
			x.last = (i == n - 1);
			pending_bytes.push_back(x);
		end
		bytes_queued += n;
	endtask

	// Mostly well-formed frames matching the current registers, the rest broken.
	task automatic random_frame();
		int          r;
		int          hi;
		int          t;
		int          pay;
		logic [7:0]  len;
		logic [7:0]  typ;
		logic [7:0]  ver;
		logic [7:0]  sync_v;
		logic [15:0] flip;
		r = $urandom_range(99);
		hi = (cfg_max > DEPTH) ? DEPTH : cfg_max;
		ver = 8'($urandom_range(255));
		if ($urandom_range(1)) ver[7:4] = cfg_vmaj;
		// short lengths dominate to keep frames cheap
		if (cfg_min <= hi && $urandom_range(9) < 7)
			len = 8'($urandom_range(cfg_min, (cfg_min + 4 < hi) ? cfg_min + 4 : hi));
		else if (cfg_min <= hi)
			len = 8'($urandom_range(cfg_min, hi));
		else
			len = 8'($urandom_range(DEPTH));
		if (cfg_mask != 0 && $urandom_range(9) != 0) begin
			t = $urandom_range(31);
			while (!cfg_mask[t]) t = $urandom_range(31);
			typ = 8'(t);
		end else begin
			typ = 8'($urandom_range(255));
		end
		sync_v = cfg_sync;
		pay = len;
		flip = 16'd0;

		if (r < 55) begin
			queue_frame(sync_v, ver, typ, len, 8'($urandom_range(255)), pay, flip, 0);
		end else if (r < 63) begin
			sync_v = cfg_sync ^ 8'($urandom_range(255, 1));
			queue_frame(sync_v, ver, typ, len, 8'($urandom_range(255)), pay, flip, 0);
		end else if (r < 70) begin
			queue_frame(sync_v, ver, typ, len, 8'($urandom_range(255)), pay, flip,
				$urandom_range(6, 1));
		end else if (r < 77) begin
			len = 8'($urandom_range(255, LONG_LIMIT + 1));
			queue_frame(sync_v, ver, typ, len, 8'($urandom_range(255)), $urandom_range(4),
				flip, 0);
		end else if (r < 85) begin
			if (len > 0 && $urandom_range(1))
				pay = $urandom_range(len - 1, 0);
			else
				pay = len + 1 + $urandom_range(2);
			queue_frame(sync_v, ver, typ, len, 8'($urandom_range(255)), pay, flip, 0);
		end else if (r < 93) begin
			flip = 16'($urandom_range(16'hFFFF, 1));
			queue_frame(sync_v, ver, typ, len, 8'($urandom_range(255)), pay, flip, 0);
		end else begin
			queue_noise($urandom_range(12, 1));
		end
	endtask

	// back-to-back register writes, write enable held high across them
	task automatic program_regs(input logic [7:0] s, input logic [31:0] m,
			input logic [3:0] v, input logic [4:0] mn, input logic [4:0] mx);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= lfd_pkg::REG_SYNC_BYTE;
		cfg_wdata <= {24'd0, s};
		@(posedge clk);
		cfg_addr <= lfd_pkg::REG_KNOWN_TYPE_MASK;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_addr <= lfd_pkg::REG_VERSION_MAJOR;
		cfg_wdata <= {28'd0, v};
		@(posedge clk);
		cfg_addr <= lfd_pkg::REG_MIN_LENGTH;
		cfg_wdata <= {27'd0, mn};
		@(posedge clk);
		cfg_addr <= lfd_pkg::REG_MAX_LENGTH;
		cfg_wdata <= {27'd0, mx};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_sync = s;
		cfg_mask = m;
		cfg_vmaj = v;
		cfg_min = mn;
		cfg_max = mx;
		settings_done++;
	endtask

	// Input driver: on a transfer feed the predictor, then offer the next
	// byte unless the random gap says wait. Held while tvalid && !tready.
	always @(posedge clk or negedge arst_n) begin : byte_driver
		byte_xfer_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				bytes_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.data;
					s_axis_tlast <= nxt.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output ready: random back-pressure, plus one long hold-off on request
	// so the decoder backs up and stalls its input.
	int hold_left;
	bit pressure_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			pressure_done <= 1'b0;
		end else if (pressure_go && !pressure_done) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			pressure_done <= 1'b1;
		end else if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic string describe(input frame_result_t r);
		return {$sformatf("st=%0d ver=%02h typ=%02h len=%0d role=%02h vm=%0b ",
				r.fields.status, r.fields.version, r.fields.msg_type,
				r.fields.payload_length, r.fields.sender_role, r.fields.version_mismatch),
			$sformatf("crc_rx=%04h crc=%04h byte=%02h idx=%0d last=%0b",
				r.fields.crc_received, r.fields.crc_computed, r.fields.payload_byte,
				r.fields.payload_index, r.last)};
	endfunction

	// Result monitor: unpack the transfer and check against the oldest expectation.
	always @(posedge clk) begin : result_monitor
		frame_result_t got;
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.fields.status = m_axis_tuser;
			got.fields.version = m_axis_tdata[7:0];
			got.fields.msg_type = m_axis_tdata[15:8];
			got.fields.payload_length = m_axis_tdata[20:16];
			got.fields.sender_role = m_axis_tdata[28:21];
			got.fields.version_mismatch = m_axis_tdata[29];
			got.fields.crc_received = m_axis_tdata[45:30];
			got.fields.crc_computed = m_axis_tdata[60:46];
			got.fields.payload_byte = m_axis_tdata[68:61];
			got.fields.payload_index = m_axis_tdata[72:69];
			got.last = m_axis_tlast;
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result %s", $realtime, describe(got));
			end else begin
				want = expected_results.pop_front();
				if (got.fields.status !== want.fields.status
						|| got.fields.version !== want.fields.version
						|| got.fields.msg_type !== want.fields.msg_type
						|| got.fields.payload_length !== want.fields.payload_length
						|| got.fields.sender_role !== want.fields.sender_role
						|| got.fields.version_mismatch !== want.fields.version_mismatch
						|| got.fields.crc_received !== want.fields.crc_received
						|| got.fields.crc_computed !== want.fields.crc_computed
						|| got.fields.payload_byte !== want.fields.payload_byte
						|| got.fields.payload_index !== want.fields.payload_index
						|| got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(got));
					end
				end
			end
		end
	end

	// Phase sequencer: registers, idle mix, directed frames, random frames,
	// then drain before the next register change.
	initial begin : sequencer
		int start;
		for (int i = 0; i < 8; i++) status_seen[i] = 0;
		cfg_sync = 8'h00;
		cfg_mask = 32'h0;
		cfg_vmaj = 4'd1;
		cfg_min = 5'd5;
		cfg_max = 5'd16;
		clear_frame();
		for (int i = 0; i < DEPTH; i++) payload_mem[i] = 8'd0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_regs(8'hA5, 32'hFFFF_FFFF, 4'd1, 5'd0, 5'd16);
				1: program_regs(8'h00, 32'h0000_0000, 4'd0, 5'd0, 5'd0);
				2: program_regs(8'hFF, 32'h8000_0001, 4'hF, 5'd16, 5'd31);  // max past buffer
				3: program_regs(8'h3C, $urandom, 4'($urandom_range(15)), 5'd10, 5'd4);  // min > max
				default: program_regs(8'($urandom_range(255)),
					$urandom_range(1) ? 32'hFFFF_FFFF : $urandom, 4'($urandom_range(15)),
					5'($urandom_range(8)), 5'($urandom_range(31)));
			endcase

			// sender-light/receiver-heavy, then swapped, then free running
			if (ph < 2) begin
				tx_idle_pct = 23;
				rx_idle_pct = 60;
			end else if (ph < 4) begin
				tx_idle_pct = 60;
				rx_idle_pct = 23;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			case (ph)
				0: begin
					queue_frame(8'hA5, 8'h10, 8'd0, 8'd0, 8'h00, 0, 16'h0, 0);     // empty payload
					queue_frame(8'hA5, 8'hFF, 8'd31, 8'd16, 8'hFF, 16, 16'h0, 0);  // full, ver off
					queue_frame(8'h5A, 8'h10, 8'd1, 8'd0, 8'h00, 0, 16'h0, 0);     // bad sync
					queue_frame(8'hA5, 8'h10, 8'd1, 8'd2, 8'h00, 2, 16'h0, 1);     // one byte
					queue_frame(8'hA5, 8'h10, 8'd1, 8'd255, 8'h00, 0, 16'h0, 0);   // length > 64
					queue_frame(8'hA5, 8'h10, 8'd1, 8'd64, 8'h00, 0, 16'h0, 0);    // at long limit
					queue_frame(8'hA5, 8'h10, 8'd1, 8'd0, 8'h00, 0, 16'h8000, 0);  // crc top bit
					queue_frame(8'hA5, 8'h10, 8'd32, 8'd0, 8'h00, 0, 16'h0, 0);    // wide type
				end
				1: begin
					queue_frame(8'h00, 8'h00, 8'd0, 8'd0, 8'h00, 0, 16'h0, 0);     // no type known
					queue_frame(8'h00, 8'h00, 8'd0, 8'd1, 8'h00, 1, 16'h0, 0);     // above max 0
				end
				3: begin
					queue_frame(8'h3C, 8'h00, 8'd0, 8'd5, 8'h00, 5, 16'h0, 0);
				end
				5: begin
					// long output stall while frames with a correct CRC keep coming
					pressure_go = 1'b1;
					for (int i = 0; i < 2; i++)
						queue_frame(cfg_sync, 8'($urandom_range(255)), 8'd0, 8'd2, 8'h33, 2,
							16'h0, 0);
				end
				default: ;
			endcase

			start = bytes_queued;
			while (bytes_queued - start < RAND_BYTES) random_frame();

			while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
				@(posedge clk);
			// pipeline may still hold a frame with no result yet
			repeat (8) @(posedge clk);
		end

		$display("Covered %0d frames, %0d bytes, %0d register settings, %0d results checked",
			frames_seen, bytes_sent, settings_done, results_checked);
		$display("Outcomes ok/sync/short/range/mismatch/crc/type: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
			status_seen[lfd_pkg::ST_OK], status_seen[lfd_pkg::ST_BAD_SYNC],
			status_seen[lfd_pkg::ST_SHORT], status_seen[lfd_pkg::ST_LEN_RANGE],
			status_seen[lfd_pkg::ST_LEN_MISM], status_seen[lfd_pkg::ST_CRC],
			status_seen[lfd_pkg::ST_UNK_TYPE]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#400000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
